### rtl/epsm_pkg.sv
package epsm_pkg;

   typedef logic [15:0]        cap_type;
   typedef logic [31:0]        ms_type;
   typedef logic signed [15:0] speed_type;
   typedef logic [15:0]        csr_data_type;
   typedef logic [2:0]         csr_index_type;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_STALL_TIMEOUT = 3'd0;
   localparam csr_index_type CSR_MAX_PERIOD    = 3'd1;
   localparam csr_index_type CSR_TICKS_PER_REV = 3'd2;
   localparam csr_index_type CSR_INVERT_RIGHT  = 3'd3;
   localparam csr_index_type CSR_INVERT_LEFT   = 3'd4;

   // Request operation codes.
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // Register reset values.
   localparam logic [15:0] STALL_TIMEOUT_RESET = 16'd250;
   localparam logic [15:0] MAX_PERIOD_RESET    = 16'd62000;
   localparam logic [15:0] TICKS_PER_REV_RESET = 16'd1170;
   localparam logic        INVERT_RIGHT_RESET  = 1'b1;
   localparam logic        INVERT_LEFT_RESET   = 1'b0;

   // 60,000,000 us per minute times 100 for rpm x 100.
   localparam int          NUM_W           = 33;
   localparam logic [32:0] SPEED_NUMERATOR = 33'd6000000000;
   localparam logic [5:0]  DIV_STEPS       = 6'd33;

   localparam speed_type SPEED_MAX = 16'sd32767;
   localparam speed_type SPEED_MIN = -16'sd32768;

endpackage

### rtl/epsm_req_if.sv
interface epsm_req_if;
   import epsm_pkg::*;

   logic    valid;
   logic    ready;
   logic    operation;
   logic    channel;
   cap_type capture_us;
   logic    phase_b;
   ms_type  now_ms;

   modport source (output valid, operation, channel, capture_us, phase_b, now_ms,
                   input ready);
   modport sink (input valid, operation, channel, capture_us, phase_b, now_ms,
                 output ready);
endinterface

### rtl/epsm_rsp_if.sv
interface epsm_rsp_if;
   import epsm_pkg::*;

   logic      valid;
   logic      ready;
   speed_type speed_right;
   speed_type speed_left;

   modport source (output valid, speed_right, speed_left, input ready);
   modport sink (input valid, speed_right, speed_left, output ready);
endinterface

### rtl/encoder_period_speed_meter_unit.sv
// An edge request that updates the speed passes through the multiply state, 33 divide
// steps, the saturation state and the output state before its response is loaded.
// An edge request that leaves the speed alone goes straight to the output state, and a stall
// check visits both channels in the stall state first. One request is taken at a time; the
// next is accepted once the sequencer is back in idle after loading the previous response.
// Reset (synchronous, active high) restores register defaults and zeroes all channel state.
module encoder_period_speed_meter_unit (
   input  logic                   clock,
   input  logic                   reset,
   epsm_req_if.sink               req,
   epsm_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  epsm_pkg::csr_index_type csr_index,
   input  epsm_pkg::csr_data_type  csr_wdata
);
   import epsm_pkg::*;

   // Sequencer states. MUL forms the divisor, DIV runs the shared restoring
   // divider one quotient bit per cycle, FIN saturates and stores the speed,
   // STALL walks the two channels through one shared age comparator, and DONE
   // hands the result to the output register.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_STALL = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   // Configuration registers.
   logic [15:0] stall_timeout_ff, max_period_ff, ticks_per_rev_ff;
   logic        invert_right_ff, invert_left_ff;

   // Per-channel state, index 0 is the right motor, index 1 the left.
   logic [1:0][15:0] last_cap_ff, last_cap_in;
   logic [1:0][31:0] last_edge_ff, last_edge_in;
   logic [1:0][15:0] speed_ff, speed_in;

   // Working registers of the current request.
   logic        ch_ff, ch_in;
   logic        neg_ff, neg_in;
   logic [15:0] period_ff, period_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [5:0]  count_ff, count_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   speed_type   rsp_right_ff, rsp_right_in;
   speed_type   rsp_left_ff, rsp_left_in;

   logic        accept;
   logic [15:0] period_calc;
   logic        inv_sel;
   logic [32:0] shifted;
   logic [33:0] trial;
   logic [31:0] age;
   speed_type   speed_sat;

   assign req.ready   = (state_ff == ST_IDLE);
   assign accept      = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.speed_right = rsp_right_ff;
   assign rsp.speed_left  = rsp_left_ff;

   // Wrapping 16-bit period since the channel's previous edge.
   assign period_calc = req.capture_us - last_cap_ff[req.channel];
   assign inv_sel     = req.channel ? invert_left_ff : invert_right_ff;

   // One restoring divide step: bring down the next numerator bit and try to
   // subtract the divisor. A zero divisor never borrows, so the quotient comes
   // out all ones and saturates, as required.
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};

   // Age of the channel under inspection, modulo 2^32.
   assign age = now_ff - last_edge_ff[ch_ff];

   // Sign and saturate the quotient to int16.
   always_comb begin
      if (neg_ff) begin
         if (num_ff >= 33'd32768) begin
            speed_sat = SPEED_MIN;
         end else begin
            speed_sat = -$signed(num_ff[15:0]);
         end
      end else begin
         if (num_ff > 33'd32767) begin
            speed_sat = SPEED_MAX;
         end else begin
            speed_sat = $signed(num_ff[15:0]);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      last_cap_in  = last_cap_ff;
      last_edge_in = last_edge_ff;
      speed_in     = speed_ff;
      ch_in        = ch_ff;
      neg_in       = neg_ff;
      period_in    = period_ff;
      now_in       = now_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_right_in = rsp_right_ff;
      rsp_left_in  = rsp_left_ff;

      // The consumer taking a response frees the output register.
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req.now_ms;
               if (req.operation == OP_EDGE) begin
                  // The stamp and edge time are recorded for every edge.
                  ch_in                     = req.channel;
                  neg_in                    = (req.phase_b == inv_sel);
                  period_in                 = period_calc;
                  last_cap_in[req.channel]  = req.capture_us;
                  last_edge_in[req.channel] = req.now_ms;
                  // Only a nonzero period below the limit updates the speed.
                  if (period_calc != 16'd0 && period_calc < max_period_ff) begin
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  ch_in    = 1'b0;
                  state_in = ST_STALL;
               end
            end
         end
         ST_MUL: begin
            div_in   = 32'(ticks_per_rev_ff) * 32'(period_ff);
            rem_in   = 32'd0;
            num_in   = SPEED_NUMERATOR;
            count_in = DIV_STEPS;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[31:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[31:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            count_in = count_ff - 6'd1;
            if (count_ff == 6'd1) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            speed_in[ch_ff] = speed_sat;
            state_in        = ST_DONE;
         end
         ST_STALL: begin
            // A channel is zeroed only when its age strictly exceeds the timeout.
            if (age > {16'd0, stall_timeout_ff}) begin
               speed_in[ch_ff] = 16'd0;
            end
            if (ch_ff) begin
               state_in = ST_DONE;
            end else begin
               ch_in = 1'b1;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free before loading it.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_right_in = speed_ff[0];
               rsp_left_in  = speed_ff[1];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         stall_timeout_ff <= STALL_TIMEOUT_RESET;
         max_period_ff    <= MAX_PERIOD_RESET;
         ticks_per_rev_ff <= TICKS_PER_REV_RESET;
         invert_right_ff  <= INVERT_RIGHT_RESET;
         invert_left_ff   <= INVERT_LEFT_RESET;
         last_cap_ff      <= '0;
         last_edge_ff     <= '0;
         speed_ff         <= '0;
         count_ff         <= 6'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_cap_ff  <= last_cap_in;
         last_edge_ff <= last_edge_in;
         speed_ff     <= speed_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         // Register writes are to arrive only while the block is idle; the block does not enforce it.
         if (csr_we) begin
            case (csr_index)
               CSR_STALL_TIMEOUT: stall_timeout_ff <= csr_wdata;
               CSR_MAX_PERIOD:    max_period_ff    <= csr_wdata;
               CSR_TICKS_PER_REV: ticks_per_rev_ff <= csr_wdata;
               CSR_INVERT_RIGHT:  invert_right_ff  <= csr_wdata[0];
               CSR_INVERT_LEFT:   invert_left_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      neg_ff       <= neg_in;
      period_ff    <= period_in;
      now_ff       <= now_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      rsp_right_ff <= rsp_right_in;
      rsp_left_ff  <= rsp_left_in;
   end

   // The divide counter runs only while the divider is active.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (count_ff == 6'd0))
      else $error("divide counter active outside the divide state");

   // A response is loaded only from the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response loaded outside the output state");

   // Stored speeds do not move while a division is in flight.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> $stable(speed_ff))
      else $error("speed changed during division");

   // An accepted request always starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start the sequencer");

endmodule
